>>> hw/rtl/mla_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mla_pkg: shared types and constants of the linear arrangement solver
// Payload structs, command bundle, action codes and fixed widths.
// ----------------------------------------------------------------------------
package mla_pkg;

    localparam int MAX_VERTICES_DEF = 12;
    localparam int VC_W             = 4;
    localparam int COST_OUT_W       = 10;
    localparam int COST_W           = 16;
    localparam int CUT_W            = 10;

    localparam logic [VC_W-1:0]       VC_RESET = 4'd12;
    localparam logic [COST_OUT_W-1:0] COST_SAT = 10'd1023;

    localparam logic ACT_ADD_EDGE = 1'b0;
    localparam logic ACT_SOLVE    = 1'b1;

    typedef struct packed {
        logic       action;
        logic [3:0] endpoint_a;
        logic [3:0] endpoint_b;
    } t_in_item;

    typedef struct packed {
        logic [3:0]            position;
        logic [3:0]            vertex;
        logic [COST_OUT_W-1:0] total_cost;
        logic                  last;
    } t_out_item;

    // Command bundle from the controller to the datapath; emit and clr_adj can be set together.
    typedef struct packed {
        logic add_edge;
        logic init;
        logic rd_s;
        logic rd_t;
        logic rd_full;
        logic cap_s;
        logic upd;
        logic emit;
        logic clr_adj;
    } t_cmd;

endpackage

>>> hw/rtl/mla_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mla_datapath: subset table, adjacency and relaxation logic
// Holds the per-subset memory, compares a candidate against a stored subset
// and forms the result items.
// ----------------------------------------------------------------------------
module mla_datapath #(
    parameter int MAX_VERTICES = mla_pkg::MAX_VERTICES_DEF,
    parameter int VI_W         = $clog2(MAX_VERTICES),
    parameter int NW           = $clog2(MAX_VERTICES + 1)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  mla_pkg::t_cmd         i_cmd,
    input  mla_pkg::t_in_item     i_in_item,
    input  logic [MAX_VERTICES-1:0] i_s,
    input  logic [MAX_VERTICES-1:0] i_full,
    input  logic [VI_W-1:0]       i_bit,
    input  logic [VI_W-1:0]       i_pos,
    input  logic [NW-1:0]         i_n,
    output mla_pkg::t_out_item    o_out_item
);
    localparam int ORD_W = MAX_VERTICES * VI_W;
    localparam int ENT_W = mla_pkg::COST_W + mla_pkg::CUT_W + ORD_W;
    localparam int DEPTH = 1 << MAX_VERTICES;

    logic [ENT_W-1:0] r_mem [DEPTH];
    logic [ENT_W-1:0] r_rdat;
    logic [ENT_W-1:0] r_sdat;
    logic [MAX_VERTICES-1:0] r_adj [MAX_VERTICES];
    mla_pkg::t_out_item r_out;

    logic [MAX_VERTICES-1:0] t_mask, ext_onehot, row, rd_addr, wr_addr;
    logic [mla_pkg::COST_W-1:0] s_cost, t_cost, cand_cost;
    logic [mla_pkg::CUT_W-1:0]  s_cut, new_cut, k, pop_in, pop_out;
    logic [ORD_W-1:0] s_ord, t_ord, cand;
    logic first, better, we;
    logic [ENT_W-1:0] wr_data;
    logic [VI_W-1:0] elem;
    logic [7:0] a8, b8;
    logic edge_ok;

    always_comb begin
        for (int i = 0; i < MAX_VERTICES; i++) begin
            ext_onehot[i] = (VI_W'(i) == i_bit);
        end
        t_mask = i_s | ext_onehot;
        row    = r_adj[i_bit];
        s_cost = r_sdat[ENT_W-1 -: mla_pkg::COST_W];
        s_cut  = r_sdat[ORD_W +: mla_pkg::CUT_W];
        s_ord  = r_sdat[ORD_W-1:0];
        t_cost = r_rdat[ENT_W-1 -: mla_pkg::COST_W];
        t_ord  = r_rdat[ORD_W-1:0];
        k       = '0;
        pop_in  = '0;
        pop_out = '0;
        for (int i = 0; i < MAX_VERTICES; i++) begin
            k       = k + mla_pkg::CUT_W'(i_s[i]);
            pop_in  = pop_in + mla_pkg::CUT_W'(row[i] & i_s[i]);
            pop_out = pop_out + mla_pkg::CUT_W'(row[i] & ~i_s[i] & i_full[i]);
        end
        // Candidate order: the order of s with the new vertex appended at k.
        cand = s_ord;
        for (int j = 0; j < MAX_VERTICES; j++) begin
            if (mla_pkg::CUT_W'(j) == k) begin
                cand[ORD_W-1-j*VI_W -: VI_W] = i_bit;
            end
        end
        cand_cost = s_cost + mla_pkg::COST_W'(s_cut);
        new_cut   = s_cut - pop_in + pop_out;
        // The first visit of t comes from t minus its highest vertex.
        first    = ((i_s >> i_bit) == '0);
        better   = first || (cand_cost < t_cost) ||
                   ((cand_cost == t_cost) && (cand < t_ord));

        we      = i_cmd.init || (i_cmd.upd && better);
        wr_addr = i_cmd.init ? '0 : t_mask;
        wr_data = i_cmd.init ? '0 : {cand_cost, new_cut, cand};
        priority if (i_cmd.rd_t) begin
            rd_addr = t_mask;
        end else if (i_cmd.rd_full) begin
            rd_addr = i_full;
        end else begin
            rd_addr = i_s;
        end

        elem = s_ord[ORD_W-1-int'(i_pos)*VI_W -: VI_W];
        a8   = {4'd0, i_in_item.endpoint_a} - 8'd1;
        b8   = {4'd0, i_in_item.endpoint_b} - 8'd1;
        edge_ok = (i_in_item.endpoint_a != 4'd0) && (i_in_item.endpoint_b != 4'd0)
               && ({4'd0, i_in_item.endpoint_a} <= 8'(MAX_VERTICES))
               && ({4'd0, i_in_item.endpoint_b} <= 8'(MAX_VERTICES))
               && (i_in_item.endpoint_a != i_in_item.endpoint_b);
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (i_cmd.rd_s || i_cmd.rd_t || i_cmd.rd_full) begin
            r_rdat <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap_s) begin
            r_sdat <= r_rdat;
        end
        if (i_cmd.emit) begin
            r_out.position   <= 4'(i_pos);
            r_out.vertex     <= 4'(8'(elem) + 8'd1);
            r_out.total_cost <= (s_cost > mla_pkg::COST_W'(mla_pkg::COST_SAT)) ?
                                mla_pkg::COST_SAT : mla_pkg::COST_OUT_W'(s_cost);
            r_out.last       <= (NW'(i_pos) + NW'(1)) == i_n;
        end
    end

    // The adjacency starts empty after reset and is emptied after each solve.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clr_adj) begin
            for (int i = 0; i < MAX_VERTICES; i++) begin
                r_adj[i] <= '0;
            end
        end else if (i_cmd.add_edge && edge_ok) begin
            r_adj[VI_W'(a8)][VI_W'(b8)] <= 1'b1;
            r_adj[VI_W'(b8)][VI_W'(a8)] <= 1'b1;
        end
    end

    assign o_out_item = r_out;

endmodule

>>> hw/rtl/mla_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mla_ctrl: sequencer of the linear arrangement solver
// Walks subsets and vertex extensions, then emits the best order.
// ----------------------------------------------------------------------------
module mla_ctrl #(
    parameter int MAX_VERTICES = mla_pkg::MAX_VERTICES_DEF,
    parameter int VI_W         = $clog2(MAX_VERTICES),
    parameter int NW           = $clog2(MAX_VERTICES + 1)
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    input  mla_pkg::t_in_item       i_in_item,
    output logic                    o_in_stall,
    input  logic                    i_out_stall,
    output logic                    o_out_valid,
    input  logic                    i_cfg_we,
    input  logic [mla_pkg::VC_W-1:0] i_cfg_data,
    output mla_pkg::t_cmd           o_cmd,
    output logic [MAX_VERTICES-1:0] o_s,
    output logic [MAX_VERTICES-1:0] o_full,
    output logic [VI_W-1:0]         o_bit,
    output logic [VI_W-1:0]         o_pos,
    output logic [NW-1:0]           o_n
);
    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_INIT = 4'd1;
    localparam logic [3:0] ST_SRD  = 4'd2;
    localparam logic [3:0] ST_SCAP = 4'd3;
    localparam logic [3:0] ST_BRD  = 4'd4;
    localparam logic [3:0] ST_BUPD = 4'd5;
    localparam logic [3:0] ST_ERD  = 4'd6;
    localparam logic [3:0] ST_ECAP = 4'd7;
    localparam logic [3:0] ST_EMIT = 4'd8;

    logic [3:0] r_state, n_state;
    logic [mla_pkg::VC_W-1:0] r_vc;
    logic [NW-1:0] r_n, n_n, r_bit, n_bit, cfg_n;
    logic [MAX_VERTICES-1:0] r_s, n_s, full;
    logic [VI_W-1:0] r_pos, n_pos;
    logic r_out_valid, n_out_valid;
    logic accept, load, s_has_bit;
    logic [7:0] vc8;
    mla_pkg::t_cmd cmd;

    always_comb begin
        vc8 = 8'(r_vc);
        if (vc8 == 8'd0) begin
            cfg_n = NW'(1);
        end else if (vc8 > 8'(MAX_VERTICES)) begin
            cfg_n = NW'(MAX_VERTICES);
        end else begin
            cfg_n = NW'(vc8);
        end
        for (int i = 0; i < MAX_VERTICES; i++) begin
            full[i] = (NW'(i) < r_n);
        end
    end

    always_comb begin
        cmd         = '0;
        n_state     = r_state;
        n_n         = r_n;
        n_s         = r_s;
        n_bit       = r_bit;
        n_pos       = r_pos;
        accept      = i_in_valid && (r_state == ST_IDLE);
        load        = !r_out_valid || !i_out_stall;
        s_has_bit   = r_s[VI_W'(r_bit)];
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    if (i_in_item.action == mla_pkg::ACT_SOLVE) begin
                        n_n     = cfg_n;
                        n_s     = '0;
                        n_state = ST_INIT;
                    end else begin
                        cmd.add_edge = 1'b1;
                    end
                end
            end
            ST_INIT: begin
                cmd.init = 1'b1;
                n_state  = ST_SRD;
            end
            ST_SRD: begin
                if (r_s == full) begin
                    n_state = ST_ERD;
                end else begin
                    cmd.rd_s = 1'b1;
                    n_state  = ST_SCAP;
                end
            end
            ST_SCAP: begin
                cmd.cap_s = 1'b1;
                n_bit     = '0;
                n_state   = ST_BRD;
            end
            ST_BRD: begin
                if (r_bit == r_n) begin
                    n_s     = r_s + MAX_VERTICES'(1);
                    n_state = ST_SRD;
                end else if (s_has_bit) begin
                    n_bit = r_bit + NW'(1);
                end else begin
                    cmd.rd_t = 1'b1;
                    n_state  = ST_BUPD;
                end
            end
            ST_BUPD: begin
                cmd.upd = 1'b1;
                n_bit   = r_bit + NW'(1);
                n_state = ST_BRD;
            end
            ST_ERD: begin
                cmd.rd_full = 1'b1;
                n_state     = ST_ECAP;
            end
            ST_ECAP: begin
                cmd.cap_s = 1'b1;
                n_pos     = '0;
                n_state   = ST_EMIT;
            end
            ST_EMIT: begin
                if (load) begin
                    cmd.emit = 1'b1;
                    if ((NW'(r_pos) + NW'(1)) == r_n) begin
                        cmd.clr_adj = 1'b1;
                        n_state     = ST_IDLE;
                    end else begin
                        n_pos = r_pos + VI_W'(1);
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
        if (cmd.emit) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_vc        <= mla_pkg::VC_RESET;
            r_out_valid <= 1'b0;
            r_n         <= '0;
            r_s         <= '0;
            r_bit       <= '0;
            r_pos       <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_n         <= n_n;
            r_s         <= n_s;
            r_bit       <= n_bit;
            r_pos       <= n_pos;
            if (i_cfg_we) begin
                r_vc <= i_cfg_data;
            end
        end
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_cmd       = cmd;
    assign o_s         = r_s;
    assign o_full      = full;
    assign o_bit       = VI_W'(r_bit);
    assign o_pos       = r_pos;
    assign o_n         = r_n;

endmodule

>>> hw/rtl/min_linear_arrangement_dp_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// min_linear_arrangement_dp_unit: minimum linear arrangement solver
// Loads an undirected graph edge by edge and, on a solve item, finds the
// vertex order with the smallest summed prefix cut by a subset DP.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake                   Payload
//  --------  ---------  --------------------------  -------------------------
//  input     in         i_in_valid / o_in_stall     i_in_item  (t_in_item)
//  output    out        o_out_valid / i_out_stall   o_out_item (t_out_item)
//  config    in         i_cfg_we                    i_cfg_data (vertex count)
//
// An add-edge item is written to the adjacency straight from idle. A solve
// item runs the subset table through one memory port: for each subset it
// reads and captures the subset's entry, then reads each free vertex's target
// subset and updates it, stepping over each vertex already in the subset;
// then it gives one output item per cycle while the output is not stalled.
// Reset is synchronous and takes effect at once; the subset memory needs no
// clearing pass, since the first visit of every subset is known in advance.
// New input items are stalled for the whole solve and emission; the output
// register lets the last item wait while new edges are loaded.
// ----------------------------------------------------------------------------
module min_linear_arrangement_dp_unit #(
    parameter int MAX_VERTICES = mla_pkg::MAX_VERTICES_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  mla_pkg::t_in_item        i_in_item,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output mla_pkg::t_out_item       o_out_item,
    input  logic                     i_cfg_we,
    input  logic [mla_pkg::VC_W-1:0] i_cfg_data
);
    localparam int VI_W = $clog2(MAX_VERTICES);
    localparam int NW   = $clog2(MAX_VERTICES + 1);

    mla_pkg::t_cmd           cmd;
    logic [MAX_VERTICES-1:0] s, full;
    logic [VI_W-1:0]         bit_idx, pos;
    logic [NW-1:0]           n;

    // The controller sequences subsets and extensions; the datapath owns
    // the subset memory, adjacency rows and the output register.
    mla_ctrl #(
        .MAX_VERTICES(MAX_VERTICES),
        .VI_W        (VI_W),
        .NW          (NW)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_item  (i_in_item),
        .o_in_stall (o_in_stall),
        .i_out_stall(i_out_stall),
        .o_out_valid(o_out_valid),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .o_cmd      (cmd),
        .o_s        (s),
        .o_full     (full),
        .o_bit      (bit_idx),
        .o_pos      (pos),
        .o_n        (n)
    );

    mla_datapath #(
        .MAX_VERTICES(MAX_VERTICES),
        .VI_W        (VI_W),
        .NW          (NW)
    ) u_datapath (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (cmd),
        .i_in_item (i_in_item),
        .i_s       (s),
        .i_full    (full),
        .i_bit     (bit_idx),
        .i_pos     (pos),
        .i_n       (n),
        .o_out_item(o_out_item)
    );

    // Every table update uses the target entry read in the cycle before.
    a_upd_after_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.upd |-> $past(cmd.rd_t))
        else $error("table update without a prior target read");

    // A new result never overwrites one that the consumer is still holding.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.emit |-> !(o_out_valid && i_out_stall))
        else $error("result register overwritten while stalled");

    // An accepted solve item starts the table walk in the next cycle.
    a_solve_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && (i_in_item.action == mla_pkg::ACT_SOLVE))
        |=> cmd.init)
        else $error("solve item did not start the table walk");

endmodule
